FILE: src/rlq_pkg.sv
package rlq_pkg;

  // Operation codes carried by in_opcode
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2,
    OP_REVERSE  = 2'd3
  } op_t;

  // Result status codes carried by out_status
  localparam logic [2:0] STS_INSERTED = 3'd0;
  localparam logic [2:0] STS_DELETED  = 3'd1;
  localparam logic [2:0] STS_ELEMENT  = 3'd2;
  localparam logic [2:0] STS_EMPTY    = 3'd3;
  localparam logic [2:0] STS_FULL     = 3'd4;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WALK = 3'b100
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted input item
    logic exec;   // carry out the captured operation
    logic step;   // read and emit one list position
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic walk;       // captured operation walks a non-empty list
    logic walk_last;  // current walk position is the back of the list
  } sts_t;

endpackage

FILE: src/rlq_ram.sv
module rlq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/rlq_ctrl.sv
module rlq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rlq_pkg::sts_t sts,
  output rlq_pkg::cmd_t cmd
);

  rlq_pkg::state_t state_r, state_nxt;

  // Sequence: capture, execute, then walk the list when asked
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      rlq_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = rlq_pkg::S_EXEC;
        end
      end
      rlq_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.walk ? rlq_pkg::S_WALK : rlq_pkg::S_IDLE;
      end
      rlq_pkg::S_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = rlq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rlq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != rlq_pkg::S_IDLE);

  // A walk is entered only from execution
  a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlq_pkg::S_WALK) |-> ($past(state_r) == rlq_pkg::S_EXEC ||
                                      $past(state_r) == rlq_pkg::S_WALK))
    else $error("walk state entered from idle");

  // Execution always follows a capture
  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == rlq_pkg::S_EXEC))
    else $error("capture not followed by execution");

  // Only one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("overlapping commands");

endmodule

FILE: src/rlq_dp.sv
module rlq_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rlq_pkg::cmd_t      cmd,
  output rlq_pkg::sts_t      sts,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_value_res,
  output logic               out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // List state
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic [AW-1:0] pos_r, pos_nxt;

  // Captured input item
  rlq_pkg::op_t  op_r;
  logic [31:0]   val_r;

  // Result registers
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_val_r, out_val_nxt;
  logic          out_sel_ram_r, out_sel_ram_nxt;
  logic          out_last_r, out_last_nxt;

  // Memory port signals
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  logic          full_w, empty_w;
  logic [AW-1:0] cnt_m1_w;
  logic [AW-1:0] pos_sel_w;
  logic [AW:0]   sum_w, diff_w;
  logic [AW-1:0] slot_w;
  logic [AW-1:0] front_inc_w, front_dec_w;

  assign full_w   = (count_r == CW'(DEPTH));
  assign empty_w  = (count_r == '0);
  assign cnt_m1_w = AW'(count_r - CW'(1));

  // Map a list position to its slot
  assign pos_sel_w = cmd.step ? pos_r : cnt_m1_w;
  assign sum_w     = {1'b0, front_r} + {1'b0, pos_sel_w};
  assign diff_w    = (front_r >= pos_sel_w) ?
                     ({1'b0, front_r} - {1'b0, pos_sel_w}) :
                     ({1'b0, front_r} + (AW+1)'(DEPTH) - {1'b0, pos_sel_w});
  always_comb begin
    if (rev_r) begin
      slot_w = diff_w[AW-1:0];
    end else if (sum_w >= (AW+1)'(DEPTH)) begin
      slot_w = AW'(sum_w - (AW+1)'(DEPTH));
    end else begin
      slot_w = sum_w[AW-1:0];
    end
  end

  // Step the front index around the ring
  assign front_inc_w = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign front_dec_w = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);

  assign sts.walk      = ((op_r == rlq_pkg::OP_TRAVERSE) || (op_r == rlq_pkg::OP_REVERSE))
                         && !empty_w;
  assign sts.walk_last = (pos_r == cnt_m1_w);

  // Execute the captured operation or one walk step
  always_comb begin
    front_nxt       = front_r;
    count_nxt       = count_r;
    rev_nxt         = rev_r;
    pos_nxt         = pos_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_val_nxt     = out_val_r;
    out_sel_ram_nxt = out_sel_ram_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = front_r;
    ram_re          = 1'b0;
    ram_raddr       = slot_w;
    if (cmd.exec) begin
      out_valid_nxt   = 1'b1;
      out_last_nxt    = 1'b1;
      out_sel_ram_nxt = 1'b0;
      out_val_nxt     = '0;
      if (op_r == rlq_pkg::OP_INSERT) begin
        if (full_w) begin
          out_status_nxt = rlq_pkg::STS_FULL;
        end else begin
          if (!empty_w) begin
            front_nxt = rev_r ? front_inc_w : front_dec_w;
          end
          ram_we         = 1'b1;
          ram_waddr      = front_nxt;
          count_nxt      = count_r + CW'(1);
          out_status_nxt = rlq_pkg::STS_INSERTED;
          out_val_nxt    = val_r;
        end
      end else if (empty_w) begin
        out_status_nxt = rlq_pkg::STS_EMPTY;
      end else if (op_r == rlq_pkg::OP_DELETE) begin
        ram_re          = 1'b1;
        count_nxt       = count_r - CW'(1);
        if (count_r == CW'(1)) begin
          front_nxt = '0;
        end
        out_status_nxt  = rlq_pkg::STS_DELETED;
        out_sel_ram_nxt = 1'b1;
      end else begin
        // Traverse or reverse: a reverse makes the back the front, then both walk as a traverse
        out_valid_nxt = 1'b0;
        pos_nxt       = '0;
        if ((op_r == rlq_pkg::OP_REVERSE) && (count_r > CW'(1))) begin
          front_nxt = slot_w;
          rev_nxt   = !rev_r;
        end
      end
    end else if (cmd.step) begin
      ram_re          = 1'b1;
      pos_nxt         = pos_r + AW'(1);
      out_valid_nxt   = 1'b1;
      out_status_nxt  = rlq_pkg::STS_ELEMENT;
      out_sel_ram_nxt = 1'b1;
      out_last_nxt    = sts.walk_last;
    end
  end

  // Hold list state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input transfer and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= rlq_pkg::op_t'(in_opcode);
      val_r <= in_value;
    end
    out_status_r  <= out_status_nxt;
    out_val_r     <= out_val_nxt;
    out_sel_ram_r <= out_sel_ram_nxt;
    out_last_r    <= out_last_nxt;
  end

  rlq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_res = $signed(out_sel_ram_r ? ram_rdata : out_val_r);
  assign out_last      = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_r == '0))
    else $error("empty list with nonzero front");

  a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !empty_w && (pos_r <= cnt_m1_w))
    else $error("walk step past the back of the list");

  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= AW'(DEPTH - 1))
    else $error("front index outside the ring");

endmodule

FILE: src/reversible_list_queue_top.sv
// Channel  | Ports                                      | Transfer
// ---------+--------------------------------------------+---------------------------
// input    | start, busy, in_opcode, in_value           | edge with start && !busy
// result   | out_valid, out_status, out_value_res,      | edge ending a cycle with
//          | out_last                                   | out_valid high
//
// Insert, delete and any empty or full answer keep busy high through execution
// alone, so a new item is taken once busy falls; the result strobes in the first
// cycle with busy low again.
// Traverse and reverse keep busy high through execution and then one ring memory
// read per stored entry.
// Results come in the cycle after their memory reads and end with out_last high.
// Synchronous reset clears the list to empty; no memory clearing pass is run.
// The receiver cannot stall: every result is presented for exactly one cycle.
module reversible_list_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_value_res,
  output logic               out_last
);

  rlq_pkg::cmd_t cmd;
  rlq_pkg::sts_t sts;

  rlq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  rlq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_value_res (out_value_res),
    .out_last      (out_last)
  );

endmodule
